/* sv/ptt_pkg.sv */
// Shared constants, codes and transfer types for the periodic task timer table.
package ptt_pkg;

  // Table geometry.
  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  // Queue geometry; the depth must be a power of two so the pointers wrap naturally.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Field widths.
  localparam int OP_W  = 2;
  localparam int ID_W  = 8;
  localparam int PER_W = 16;
  localparam int ST_W  = 2;

  // Operation codes on the input channel.
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  // Status codes on the result channel.
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd3;

  // Command class decided by the front end.
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP,
    CMD_BAD_ID,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ID_W-1:0]   task_id;
    logic [PER_W-1:0]  period;
    logic              one_shot;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              fired;
    logic [ID_W-1:0]   fired_task;
    logic              last;
  } res_t;

endpackage

/* sv/ptt_front.sv */
// Front end: classifies incoming commands and holds them in a short queue.
module ptt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [ptt_pkg::OP_W-1:0]  in_operation,
  input  logic [ptt_pkg::ID_W-1:0]  in_task_id,
  input  logic [ptt_pkg::PER_W-1:0] in_period,
  input  logic                      in_one_shot,
  output logic                      cmd_valid,
  output ptt_pkg::cmd_t             cmd,
  input  logic                      cmd_take
);

  ptt_pkg::cmd_t                   cls;
  ptt_pkg::cmd_t                   q_mem [ptt_pkg::Q_DEPTH];
  logic [ptt_pkg::Q_PTR_W-1:0]     wr_ptr_r;
  logic [ptt_pkg::Q_PTR_W-1:0]     rd_ptr_r;
  logic [ptt_pkg::Q_CNT_W-1:0]     cnt_r;
  logic                            do_push;
  logic                            do_pop;

  // Classify the operation; a start or stop that names task zero is rejected early.
  always_comb begin
    cls.task_id  = in_task_id;
    cls.period   = in_period;
    cls.one_shot = in_one_shot;
    unique case (in_operation)
      ptt_pkg::OP_TICK:  cls.kind = ptt_pkg::CMD_TICK;
      ptt_pkg::OP_START: cls.kind = (in_task_id == '0) ? ptt_pkg::CMD_BAD_ID
                                                       : ptt_pkg::CMD_START;
      ptt_pkg::OP_STOP:  cls.kind = (in_task_id == '0) ? ptt_pkg::CMD_BAD_ID
                                                       : ptt_pkg::CMD_STOP;
      default:           cls.kind = ptt_pkg::CMD_NOP;
    endcase
  end

  // Queue flags and transfers.
  assign in_full   = (cnt_r == ptt_pkg::Q_CNT_W'(ptt_pkg::Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd       = q_mem[rd_ptr_r];

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + ptt_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + ptt_pkg::Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + ptt_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - ptt_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

/* sv/ptt_res_q.sv */
// Result queue between the timer engine and the output channel.
module ptt_res_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_push,
  input  ptt_pkg::res_t res,
  output logic          res_full,
  output logic          out_empty,
  input  logic          out_pop,
  output ptt_pkg::res_t out_res
);

  ptt_pkg::res_t               q_mem [ptt_pkg::Q_DEPTH];
  logic [ptt_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [ptt_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [ptt_pkg::Q_CNT_W-1:0] cnt_r;
  logic                        do_push;
  logic                        do_pop;

  // Flags and transfers on both sides.
  assign res_full  = (cnt_r == ptt_pkg::Q_CNT_W'(ptt_pkg::Q_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign do_push   = res_push && !res_full;
  assign do_pop    = out_pop && !out_empty;
  assign out_res   = q_mem[rd_ptr_r];

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= res;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + ptt_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + ptt_pkg::Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + ptt_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - ptt_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

/* sv/ptt_back.sv */
// Timer engine: owns the slot table and walks it for tick and stop commands.
module ptt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  ptt_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_push,
  output ptt_pkg::res_t res,
  input  logic          res_full
);

  typedef struct packed {
    logic [ptt_pkg::ID_W-1:0]  task_id;
    logic [ptt_pkg::PER_W-1:0] period;
    logic [ptt_pkg::PER_W-1:0] ticks;
    logic                      one_shot;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EX,
    S_FIN
  } state_t;

  state_t                      state_r, state_nxt;
  logic [ptt_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [ptt_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                        tick_mode_r, tick_mode_nxt;
  logic [ptt_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [ptt_pkg::NRES_W-1:0]  nres_r, nres_nxt;
  logic                        pend_r, pend_nxt;
  logic [ptt_pkg::ID_W-1:0]    pend_task_r, pend_task_nxt;

  entry_t                      slot_mem [ptt_pkg::SLOTS];
  entry_t                      rd_a_r;
  entry_t                      rd_b_r;
  logic [ptt_pkg::IDX_W-1:0]   last_idx;
  logic                        mem_we;
  logic [ptt_pkg::IDX_W-1:0]   mem_waddr;
  entry_t                      mem_wdata;

  logic [ptt_pkg::PER_W-1:0]   tinc;
  logic                        hit;
  logic                        remove;
  logic                        report;
  logic                        stall;
  logic [ptt_pkg::CNT_W-1:0]   count_dec;
  logic [ptt_pkg::CNT_W-1:0]   idx_inc;

  // Slot table: one write port, two registered read ports (current slot and last slot).
  assign last_idx = ptt_pkg::IDX_W'(count_r - ptt_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= slot_mem[idx_r];
    rd_b_r <= slot_mem[last_idx];
  end

  // Per-slot tick evaluation on the registered read data.
  assign tinc      = rd_a_r.ticks + ptt_pkg::PER_W'(1);
  assign hit       = (tinc == rd_a_r.period);
  assign remove    = hit && rd_a_r.one_shot;
  assign report    = hit && (nres_r < ptt_pkg::NRES_W'(ptt_pkg::MAX_RESULTS));
  assign stall     = report && pend_r && res_full;
  assign count_dec = count_r - ptt_pkg::CNT_W'(1);
  assign idx_inc   = ptt_pkg::CNT_W'(idx_r) + ptt_pkg::CNT_W'(1);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    tick_mode_nxt = tick_mode_r;
    id_nxt        = id_r;
    nres_nxt      = nres_r;
    pend_nxt      = pend_r;
    pend_task_nxt = pend_task_r;
    cmd_take      = 1'b0;
    res_push      = 1'b0;
    res           = '0;
    res.status    = ptt_pkg::ST_OK;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = rd_a_r;

    unique case (state_r)
      S_IDLE: begin
        // Only take a command when a result can be queued at once.
        if (cmd_valid && !res_full) begin
          cmd_take = 1'b1;
          res.last = 1'b1;
          unique case (cmd.kind)
            ptt_pkg::CMD_TICK: begin
              if (count_r == '0) begin
                res_push   = 1'b1;
                res.status = ptt_pkg::ST_EMPTY;
              end else begin
                idx_nxt       = '0;
                nres_nxt      = '0;
                pend_nxt      = 1'b0;
                tick_mode_nxt = 1'b1;
                state_nxt     = S_RD;
              end
            end
            ptt_pkg::CMD_START: begin
              res_push = 1'b1;
              if (count_r >= ptt_pkg::CNT_W'(ptt_pkg::SLOTS)) begin
                res.status = ptt_pkg::ST_FULL;
              end else begin
                mem_we             = 1'b1;
                mem_waddr          = ptt_pkg::IDX_W'(count_r);
                mem_wdata.task_id  = cmd.task_id;
                mem_wdata.period   = cmd.period;
                mem_wdata.ticks    = '0;
                mem_wdata.one_shot = cmd.one_shot;
                count_nxt          = count_r + ptt_pkg::CNT_W'(1);
              end
            end
            ptt_pkg::CMD_STOP: begin
              if (count_r == '0) begin
                res_push   = 1'b1;
                res.status = ptt_pkg::ST_EMPTY;
              end else begin
                idx_nxt       = last_idx;
                id_nxt        = cmd.task_id;
                pend_nxt      = 1'b0;
                tick_mode_nxt = 1'b0;
                state_nxt     = S_RD;
              end
            end
            ptt_pkg::CMD_BAD_ID: begin
              res_push   = 1'b1;
              res.status = ptt_pkg::ST_INVALID;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        state_nxt = S_EX;
      end

      S_EX: begin
        if (tick_mode_r) begin
          // Ascending walk; a fired one-shot takes the last entry, which is skipped.
          if (!stall) begin
            mem_we = 1'b1;
            if (remove) begin
              mem_wdata = rd_b_r;
              count_nxt = count_dec;
            end else begin
              mem_wdata.ticks = hit ? '0 : tinc;
            end
            if (report) begin
              // The held firing is now known not to be the final one.
              if (pend_r) begin
                res_push       = 1'b1;
                res.fired      = 1'b1;
                res.fired_task = pend_task_r;
              end
              pend_nxt      = 1'b1;
              pend_task_nxt = rd_a_r.task_id;
              nres_nxt      = nres_r + ptt_pkg::NRES_W'(1);
            end
            idx_nxt = ptt_pkg::IDX_W'(idx_inc);
            if (idx_inc < (remove ? count_dec : count_r)) begin
              state_nxt = S_RD;
            end else begin
              state_nxt = S_FIN;
            end
          end
        end else begin
          // Descending walk; each match is overwritten by the last entry.
          if (rd_a_r.task_id == id_r) begin
            mem_we    = 1'b1;
            mem_wdata = rd_b_r;
            count_nxt = count_dec;
          end
          if (idx_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r - ptt_pkg::IDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end

      S_FIN: begin
        // Closing result: the held firing, or a plain status.
        if (!res_full) begin
          res_push  = 1'b1;
          res.last  = 1'b1;
          if (pend_r) begin
            res.fired      = 1'b1;
            res.fired_task = pend_task_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      tick_mode_r <= 1'b0;
      nres_r      <= '0;
      pend_r      <= 1'b0;
      id_r        <= '0;
      pend_task_r <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      tick_mode_r <= tick_mode_nxt;
      nres_r      <= nres_nxt;
      pend_r      <= pend_nxt;
      id_r        <= id_nxt;
      pend_task_r <= pend_task_nxt;
    end
  end

  // The occupancy never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ptt_pkg::CNT_W'(ptt_pkg::SLOTS))
    else $error("slot count exceeds table size");

  // The occupancy moves by at most one entry per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) ||
                      count_r == $past(count_r) + ptt_pkg::CNT_W'(1) ||
                      count_r == $past(count_r) - ptt_pkg::CNT_W'(1)))
    else $error("slot count jumped");

  // No more firings are counted than may be reported.
  a_nres_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= ptt_pkg::NRES_W'(ptt_pkg::MAX_RESULTS))
    else $error("firing count exceeds report limit");

  // A stalled tick step holds its place and leaves the table alone.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EX && tick_mode_r && stall) |-> (!mem_we ##1 state_r == S_EX))
    else $error("tick step advanced while result queue was full");

endmodule

/* sv/periodic_task_timer_table_core.sv */
// Top level of the periodic task timer table: front end, timer engine, result queue.
//
// Usage:
//   Input channel (in_push/in_full): one command per transfer. Operation 0 ticks
//   every timer, 1 starts a timer (task id, period, one-shot flag), 2 stops every
//   timer with the given task id; any other code gives a plain ok result.
//   Result channel (out_empty/out_pop): each command yields one or more results;
//   out_last marks the final result of a command. A tick yields one result per
//   firing in slot order, or a single result when nothing fires.
//   Engine: start, invalid and unknown commands, and a tick or stop on an empty
//   table, are settled in the idle state, which queues their result at once.
//   Tick and stop walk the occupied slots through the single-write,
//   registered-read slot table, each slot in a read state and then an execute
//   state, and close in a finish state; a tick step waits while a firing must
//   be queued and the result queue is full. The table holds 16 slots.
//   Reset: the table is empty and both queues are cleared; slot contents are not.
//   Stalls: when out_pop stays low the two-entry result queue fills, the engine
//   waits on its next result, and then the two-entry command queue fills and
//   in_full rises.
module periodic_task_timer_table_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [ptt_pkg::OP_W-1:0]  in_operation,
  input  logic [ptt_pkg::ID_W-1:0]  in_task_id,
  input  logic [ptt_pkg::PER_W-1:0] in_period,
  input  logic                      in_one_shot,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [ptt_pkg::ST_W-1:0]  out_status,
  output logic                      out_fired,
  output logic [ptt_pkg::ID_W-1:0]  out_fired_task,
  output logic                      out_last
);

  logic          cmd_valid;
  ptt_pkg::cmd_t cmd;
  logic          cmd_take;
  logic          res_push;
  ptt_pkg::res_t res;
  logic          res_full;
  ptt_pkg::res_t out_res;

  // Command classification and queue.
  ptt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_task_id   (in_task_id),
    .in_period    (in_period),
    .in_one_shot  (in_one_shot),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  // Timer table engine.
  ptt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // Result queue toward the output channel.
  ptt_res_q u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  // Split the result record onto its ports.
  assign out_status     = out_res.status;
  assign out_fired      = out_res.fired;
  assign out_fired_task = out_res.fired_task;
  assign out_last       = out_res.last;

endmodule
